### design/wrs_pkg.sv
package wrs_pkg;

  // fixed point and counter sizing
  localparam int FRAC_BITS  = 16;
  localparam int COUNT_BITS = 16;

  // field widths
  localparam int ACT_W  = 2;
  localparam int TAG_W  = 32;
  localparam int DATA_W = 32;
  localparam int WS_W   = 48;
  localparam int CNT_W  = 16;
  localparam int RND_W  = 16;

  // stream payload widths
  localparam int IN_TDATA_W  = TAG_W + 3 * DATA_W + CNT_W + RND_W;
  localparam int OUT_TDATA_W = TAG_W + 2 * DATA_W + CNT_W + WS_W;

  // serial multiplier and divider sizing
  localparam int MUL_A_W = WS_W;
  localparam int MUL_B_W = (COUNT_BITS > DATA_W) ? COUNT_BITS : DATA_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int DEN_W   = DATA_W + COUNT_BITS;
  localparam int NUM_W   = WS_W + FRAC_BITS;
  localparam int SUMC_W  = ((COUNT_BITS > CNT_W) ? COUNT_BITS : CNT_W) + 1;

  localparam logic [WS_W-1:0]       WS_MAX    = '1;
  localparam logic [DATA_W-1:0]     DATA_MAX  = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [ACT_W-1:0] {
    ACT_RESET   = 2'd0,
    ACT_ADD     = 2'd1,
    ACT_MERGE   = 2'd2,
    ACT_REPLACE = 2'd3
  } action_e;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  function automatic logic [WS_W-1:0] sat_ws_add(logic [WS_W-1:0] a, logic [WS_W-1:0] b);
    logic [WS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WS_W] ? WS_MAX : s[WS_W-1:0];
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_cnt_add(logic [COUNT_BITS-1:0] a,
                                                        logic [CNT_W-1:0] b);
    logic [SUMC_W-1:0] s;
    s = SUMC_W'(a) + SUMC_W'(b);
    return (s > SUMC_W'(COUNT_MAX)) ? COUNT_MAX : s[COUNT_BITS-1:0];
  endfunction

endpackage

### design/weighted_reservoir_sampler_unit.sv
// Weighted reservoir sampler: holds one reservoir (sample tag, its target pdf, contribution
// weight W, candidate count M and a saturating Q32.16 weight sum) and applies one action per
// input item (reset, add candidate, merge an incoming reservoir, replace with it), answering
// each item with one result item that shows the reservoir after the action plus a taken flag.
// Items are processed one at a time; the result sits in an output register, so the next
// item is accepted while the previous result still waits. Reset and replace go straight
// from S_IDLE to S_FIN, which loads the output register once it is free. A multiply runs
// longer the greater the bit length b of its multiplier operand, and the divide is skipped
// when the divisor is zero. Add runs the take multiply (b is the random fraction) and the
// divisor multiply (b is the count); merge adds two pdf * W multiplies (b up to 32 bits)
// and two count multiplies (b up to 16 bits). Multiplies go through the shared shift-add
// multiplier (one multiplier bit per cycle, stopping early once the remaining bits are
// zero), and W comes from the restoring divider, which forms it one quotient bit per
// cycle over 64 steps.
module weighted_reservoir_sampler_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input items
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // sample_tag, weight, target_pdf, incoming_contribution, incoming_count, random_fraction
  input  logic [wrs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // action
  input  logic [wrs_pkg::ACT_W-1:0]       s_axis_tuser,
  // result items
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // chosen_tag, chosen_pdf, contribution, candidate_count, weight_total
  output logic [wrs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // taken
  output logic                            m_axis_tuser
);
  import wrs_pkg::*;

  // sequencer: each multiply state issues once, then waits for the multiplier
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_TAKE = 9'b000000010,  // rand * weight_sum against weight << 16
    S_PW1  = 9'b000000100,  // held pdf * held W
    S_W1   = 9'b000001000,  // times held count
    S_PW2  = 9'b000010000,  // incoming pdf * incoming W
    S_W2   = 9'b000100000,  // times incoming count
    S_DEN  = 9'b001000000,  // pdf * count divisor
    S_DIV  = 9'b010000000,  // W = weight_sum / divisor
    S_FIN  = 9'b100000000   // hand result to output register
  } state_e;

  // input field offsets inside tdata
  localparam int O_TAG = 0;
  localparam int O_WGT = O_TAG + TAG_W;
  localparam int O_PDF = O_WGT + DATA_W;
  localparam int O_INW = O_PDF + DATA_W;
  localparam int O_INM = O_INW + DATA_W;
  localparam int O_RND = O_INM + CNT_W;

  logic [TAG_W-1:0]  f_tag;
  logic [DATA_W-1:0] f_wgt;
  logic [DATA_W-1:0] f_pdf;
  logic [DATA_W-1:0] f_inw;
  logic [CNT_W-1:0]  f_inm;
  logic [RND_W-1:0]  f_rnd;

  assign f_tag = s_axis_tdata[O_TAG +: TAG_W];
  assign f_wgt = s_axis_tdata[O_WGT +: DATA_W];
  assign f_pdf = s_axis_tdata[O_PDF +: DATA_W];
  assign f_inw = s_axis_tdata[O_INW +: DATA_W];
  assign f_inm = s_axis_tdata[O_INM +: CNT_W];
  assign f_rnd = s_axis_tdata[O_RND +: RND_W];

  state_e state_q, state_d;
  logic   issued_q, issued_d;

  // reservoir state
  logic [TAG_W-1:0]      held_tag_q, held_tag_d;
  logic [DATA_W-1:0]     held_pdf_q, held_pdf_d;
  logic [DATA_W-1:0]     held_w_q, held_w_d;
  logic [COUNT_BITS-1:0] held_cnt_q, held_cnt_d;
  logic [WS_W-1:0]       ws_q, ws_d;

  // working registers
  logic [WS_W-1:0]   tmp_q, tmp_d;   // candidate weight, pw or incoming weight
  logic [DEN_W-1:0]  den_q, den_d;
  logic              taken_q, taken_d;

  // captured item
  logic [TAG_W-1:0]  in_tag_q;
  logic [DATA_W-1:0] in_pdf_q;
  logic [DATA_W-1:0] in_w_q;
  logic [CNT_W-1:0]  in_m_q;
  logic [RND_W-1:0]  rnd_q;

  // output register
  logic                   out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic                   out_taken_q;
  logic                   out_load;

  // shared units
  mul_req_t           mul_req;
  logic               mul_done;
  logic [MUL_P_W-1:0] mul_prod;
  div_req_t           div_req;
  logic               div_done;
  logic [DATA_W-1:0]  div_quo;

  wrs_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  wrs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  logic s_acc;
  logic mul_state;
  logic mul_fire;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign mul_state     = (state_q == S_TAKE) || (state_q == S_PW1) || (state_q == S_W1) ||
                         (state_q == S_PW2) || (state_q == S_W2) || (state_q == S_DEN);
  assign mul_fire      = mul_state && issued_q && mul_done;

  // product views: pdf*W rescaled, weight product clipped, take threshold
  logic [WS_W-1:0]    pw_sat;
  logic [WS_W-1:0]    w_sat;
  logic [MUL_P_W-1:0] take_thr;
  logic               take_hit;

  assign pw_sat   = (|mul_prod[MUL_P_W-1:FRAC_BITS+WS_W]) ? WS_MAX
                                                          : mul_prod[FRAC_BITS +: WS_W];
  assign w_sat    = (|mul_prod[MUL_P_W-1:WS_W]) ? WS_MAX : mul_prod[WS_W-1:0];
  assign take_thr = MUL_P_W'(tmp_q) << RND_W;
  assign take_hit = mul_prod < take_thr;

  // multiplier operand select
  always_comb begin
    mul_req.start = mul_state && !issued_q;
    mul_req.a     = '0;
    mul_req.b     = '0;
    unique case (state_q)
      S_TAKE: begin
        mul_req.a = ws_q;
        mul_req.b = MUL_B_W'(rnd_q);
      end
      S_PW1: begin
        mul_req.a = MUL_A_W'(held_pdf_q);
        mul_req.b = MUL_B_W'(held_w_q);
      end
      S_W1: begin
        mul_req.a = tmp_q;
        mul_req.b = MUL_B_W'(held_cnt_q);
      end
      S_PW2: begin
        mul_req.a = MUL_A_W'(in_pdf_q);
        mul_req.b = MUL_B_W'(in_w_q);
      end
      S_W2: begin
        mul_req.a = tmp_q;
        mul_req.b = MUL_B_W'(in_m_q);
      end
      S_DEN: begin
        mul_req.a = MUL_A_W'(held_pdf_q);
        mul_req.b = MUL_B_W'(held_cnt_q);
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
  end

  // divider: weight_sum scaled by the fraction bits over pdf * count
  assign div_req.start = (state_q == S_DIV) && !issued_q && (den_q != '0);
  assign div_req.num   = {ws_q, {FRAC_BITS{1'b0}}};
  assign div_req.den   = den_q;

  assign out_load = (state_q == S_FIN) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d     = state_q;
    issued_d    = issued_q;
    held_tag_d  = held_tag_q;
    held_pdf_d  = held_pdf_q;
    held_w_d    = held_w_q;
    held_cnt_d  = held_cnt_q;
    ws_d        = ws_q;
    tmp_d       = tmp_q;
    den_d       = den_q;
    taken_d     = taken_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    if (mul_state && !issued_q) begin
      issued_d = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          issued_d = 1'b0;
          taken_d  = 1'b0;
          unique case (action_e'(s_axis_tuser))
            ACT_RESET: begin
              held_tag_d = '0;
              held_pdf_d = '0;
              held_w_d   = '0;
              held_cnt_d = '0;
              ws_d       = '0;
              state_d    = S_FIN;
            end
            ACT_ADD: begin
              ws_d       = sat_ws_add(ws_q, WS_W'(f_wgt));
              held_cnt_d = sat_cnt_add(held_cnt_q, CNT_W'(1));
              tmp_d      = WS_W'(f_wgt);
              state_d    = S_TAKE;
            end
            ACT_MERGE: begin
              state_d = S_PW1;
            end
            ACT_REPLACE: begin
              held_tag_d = f_tag;
              held_pdf_d = f_pdf;
              held_w_d   = f_inw;
              held_cnt_d = sat_cnt_add('0, f_inm);
              taken_d    = 1'b1;
              state_d    = S_FIN;
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end
      S_TAKE: begin
        if (mul_fire) begin
          issued_d = 1'b0;
          if (take_hit) begin
            held_tag_d = in_tag_q;
            held_pdf_d = in_pdf_q;
            taken_d    = 1'b1;
          end
          state_d = S_DEN;
        end
      end
      S_PW1: begin
        if (mul_fire) begin
          issued_d = 1'b0;
          tmp_d    = pw_sat;
          state_d  = S_W1;
        end
      end
      S_W1: begin
        if (mul_fire) begin
          issued_d = 1'b0;
          ws_d     = w_sat;
          // an empty held reservoir does not keep its sample
          if (w_sat == '0) begin
            held_tag_d = '0;
            held_pdf_d = '0;
          end
          state_d = S_PW2;
        end
      end
      S_PW2: begin
        if (mul_fire) begin
          issued_d = 1'b0;
          tmp_d    = pw_sat;
          state_d  = S_W2;
        end
      end
      S_W2: begin
        if (mul_fire) begin
          issued_d   = 1'b0;
          tmp_d      = w_sat;
          ws_d       = sat_ws_add(ws_q, w_sat);
          held_cnt_d = sat_cnt_add(held_cnt_q, in_m_q);
          state_d    = S_TAKE;
        end
      end
      S_DEN: begin
        if (mul_fire) begin
          issued_d = 1'b0;
          den_d    = mul_prod[DEN_W-1:0];
          state_d  = S_DIV;
        end
      end
      S_DIV: begin
        if (!issued_q) begin
          if (den_q == '0) begin
            // zero divisor gives zero contribution weight
            held_w_d = '0;
            state_d  = S_FIN;
          end else begin
            issued_d = 1'b1;
          end
        end else if (div_done) begin
          issued_d = 1'b0;
          held_w_d = div_quo;
          state_d  = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issued_q    <= 1'b0;
      held_tag_q  <= '0;
      held_pdf_q  <= '0;
      held_w_q    <= '0;
      held_cnt_q  <= '0;
      ws_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      held_tag_q  <= held_tag_d;
      held_pdf_q  <= held_pdf_d;
      held_w_q    <= held_w_d;
      held_cnt_q  <= held_cnt_d;
      ws_q        <= ws_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tmp_q   <= tmp_d;
    den_q   <= den_d;
    taken_q <= taken_d;
    if (s_acc) begin
      in_tag_q <= f_tag;
      in_pdf_q <= f_pdf;
      in_w_q   <= f_inw;
      in_m_q   <= f_inm;
      rnd_q    <= f_rnd;
    end
    if (out_load) begin
      out_data_q  <= {ws_q, CNT_W'(held_cnt_q), held_w_q, held_pdf_q, held_tag_q};
      out_taken_q <= taken_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_taken_q;

endmodule

### design/wrs_mul.sv
module wrs_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  wrs_pkg::mul_req_t            req_i,
  output logic                         done_o,
  output logic [wrs_pkg::MUL_P_W-1:0]  prod_o
);
  import wrs_pkg::*;

  // shift-add, one multiplier bit per cycle, stops once no bits remain
  logic               busy_q, busy_d;
  logic [MUL_P_W-1:0] a_q, a_d;
  logic [MUL_P_W-1:0] acc_q, acc_d;
  logic [MUL_B_W-1:0] b_q, b_d;

  assign done_o = busy_q && (b_q == '0);
  assign prod_o = acc_q;

  always_comb begin
    busy_d = busy_q;
    a_d    = a_q;
    acc_d  = acc_q;
    b_d    = b_q;
    priority if (req_i.start && !busy_q) begin
      a_d    = MUL_P_W'(req_i.a);
      b_d    = req_i.b;
      acc_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q == '0) begin
        busy_d = 1'b0;
      end else begin
        if (b_q[0]) begin
          acc_d = acc_q + a_q;
        end
        a_d = a_q << 1;
        b_d = b_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    acc_q <= acc_d;
    b_q   <= b_d;
  end

endmodule

### design/wrs_div.sv
module wrs_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  wrs_pkg::div_req_t            req_i,
  output logic                         done_o,
  output logic [wrs_pkg::DATA_W-1:0]   quo_o
);
  import wrs_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);

  // restoring division, one quotient bit per cycle, sticky overflow above DATA_W
  logic              busy_q, busy_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic              ovf_q, ovf_d;

  logic [DEN_W:0] rem_sh;
  logic [DEN_W:0] sub;
  logic           ge;

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign sub    = rem_sh - {1'b0, den_q};
  assign ge     = rem_sh >= {1'b0, den_q};

  assign done_o = busy_q && (cnt_q == '0);
  assign quo_o  = ovf_q ? DATA_MAX : quo_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    ovf_d  = ovf_q;
    priority if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = STEP_W'(NUM_W);
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      quo_d  = '0;
      ovf_d  = 1'b0;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
        num_d = num_q << 1;
        rem_d = ge ? sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        ovf_d = ovf_q | quo_q[DATA_W-1];
        quo_d = {quo_q[DATA_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

endmodule

### design/wrs_checker.sv
module wrs_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [wrs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic [wrs_pkg::ACT_W-1:0]       s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [wrs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser
);
  import wrs_pkg::*;

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("item accepted while busy");

  // reset action with a free output gives an all-zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser == ACT_RESET) && !m_axis_tvalid |=> ##1
      (m_axis_tvalid && (m_axis_tdata == '0) && !m_axis_tuser))
    else $error("reset action result not zero");

  // replace action reports the incoming tag as taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser == ACT_REPLACE) && !m_axis_tvalid |=> ##1
      (m_axis_tvalid && m_axis_tuser &&
       (m_axis_tdata[TAG_W-1:0] == $past(s_axis_tdata[TAG_W-1:0], 2))))
    else $error("replace action result wrong");

endmodule

bind weighted_reservoir_sampler_unit wrs_checker u_wrs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### sim/tb_weighted_reservoir_sampler_unit.sv
`timescale 1ns / 100ps

module tb_weighted_reservoir_sampler_unit;
  import wrs_pkg::*;

  // timing of the run
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int TAIL_CYCLES    = 300;   // quiet time after the last result
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no item moving on either side

  // one input item, unpacked
  typedef struct {
    action_e   act;
    bit [31:0] tag;
    bit [31:0] weight;
    bit [31:0] pdf;
    bit [31:0] inc_w;
    bit [15:0] inc_m;
    bit [15:0] rnd;
  } cand_t;

  // one result item, unpacked
  typedef struct {
    bit [31:0] tag;
    bit [31:0] pdf;
    bit [31:0] contrib;
    bit [15:0] count;
    bit [47:0] total;
    bit        taken;
  } reservoir_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // tag, weight, pdf, incoming W, incoming M, random
  logic [ACT_W-1:0]       s_axis_tuser;   // action
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // tag, pdf, W, count, weight total
  logic                   m_axis_tuser;   // taken

  weighted_reservoir_sampler_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // predicted reservoir contents
  bit [31:0] res_tag;
  bit [31:0] res_pdf;
  bit [31:0] res_w;
  bit [15:0] res_m;
  bit [47:0] res_wsum;

  reservoir_t expected_q[$];

  int  n_sent;
  int  n_results;
  int  n_errors;
  int  idle_cycles;
  bit  gaps_on     = 1'b1;  // sender inserts random gaps
  bit  sink_stalls = 1'b1;  // receiver drops ready at random
  bit  hold_req;
  bit  hold_active;

  // ---------------------------------------------------------------------------------------
  // fixed point helpers of the predictor
  // ---------------------------------------------------------------------------------------

  function automatic bit [47:0] sum48_sat(bit [47:0] a, bit [47:0] b);
    bit [48:0] s;
    s = 49'(a) + 49'(b);
    return s[48] ? '1 : s[47:0];
  endfunction

  function automatic bit [15:0] count_add_sat(bit [15:0] a, bit [15:0] b);
    bit [16:0] s;
    s = 17'(a) + 17'(b);
    return s[16] ? '1 : s[15:0];
  endfunction

  // resampling weight pdf * W * M of a whole reservoir, 48-bit saturated
  function automatic bit [47:0] reservoir_weight(bit [31:0] pdf, bit [31:0] w, bit [15:0] m);
    bit [63:0] pw;
    pw = (64'(pdf) * 64'(w)) >> FRAC_BITS;
    if (m == 0 || pw == 0) return '0;
    if (pw > 64'hFFFF_FFFF_FFFF / 64'(m)) return '1;
    return 48'(pw * 64'(m));
  endfunction

  // W = sum / (pdf * M), zero on a zero divisor, saturated at 32 bits
  function automatic bit [31:0] contribution_of(bit [47:0] ws, bit [31:0] pdf, bit [15:0] m);
    bit [63:0] den;
    bit [63:0] quo;
    den = 64'(pdf) * 64'(m);
    if (den == 0) return '0;
    quo = {ws, 16'h0} / den;
    return (quo > 64'hFFFF_FFFF) ? '1 : quo[31:0];
  endfunction

  // candidate wins when rnd * sum < w * 2^16
  function automatic bit wins(bit [15:0] rnd, bit [47:0] ws, bit [47:0] w);
    return (64'(rnd) * 64'(ws)) < {w, 16'h0};
  endfunction

  // applies one item to the predicted reservoir and returns what the block should report
  function automatic reservoir_t advance_reservoir(cand_t c);
    reservoir_t r;
    bit         taken;
    bit [47:0]  w_held;
    bit [47:0]  w_inc;
    bit [47:0]  ws;
    bit [31:0]  nt;
    bit [31:0]  np;
    taken = 1'b0;
    case (c.act)
      ACT_RESET: begin
        res_tag  = '0;
        res_pdf  = '0;
        res_w    = '0;
        res_m    = '0;
        res_wsum = '0;
      end
      ACT_ADD: begin
        res_wsum = sum48_sat(res_wsum, 48'(c.weight));
        res_m    = count_add_sat(res_m, 16'd1);
        if (wins(c.rnd, res_wsum, 48'(c.weight))) begin
          res_tag = c.tag;
          res_pdf = c.pdf;
          taken   = 1'b1;
        end
        // W always uses the held pdf, old or new
        res_w = contribution_of(res_wsum, res_pdf, res_m);
      end
      ACT_MERGE: begin
        // fresh reservoir: held sample first, then the incoming one
        w_held = reservoir_weight(res_pdf, res_w, res_m);
        w_inc  = reservoir_weight(c.pdf, c.inc_w, c.inc_m);
        nt     = '0;
        np     = '0;
        ws     = w_held;
        if (wins(c.rnd, ws, w_held)) begin
          nt = res_tag;
          np = res_pdf;
        end
        ws = sum48_sat(ws, w_inc);
        if (wins(c.rnd, ws, w_inc)) begin
          nt    = c.tag;
          np    = c.pdf;
          taken = 1'b1;
        end
        res_tag  = nt;
        res_pdf  = np;
        res_m    = count_add_sat(res_m, c.inc_m);
        res_wsum = ws;
        res_w    = contribution_of(res_wsum, res_pdf, res_m);
      end
      default: begin
        // replace keeps the weight sum
        res_tag = c.tag;
        res_pdf = c.pdf;
        res_w   = c.inc_w;
        res_m   = c.inc_m;
        taken   = 1'b1;
      end
    endcase
    r.tag     = res_tag;
    r.pdf     = res_pdf;
    r.contrib = res_w;
    r.count   = res_m;
    r.total   = res_wsum;
    r.taken   = taken;
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------------------

  function automatic cand_t make_item(action_e act, bit [31:0] tag, bit [31:0] weight,
                                      bit [31:0] pdf, bit [31:0] inc_w, bit [15:0] inc_m,
                                      bit [15:0] rnd);
    cand_t c;
    c.act    = act;
    c.tag    = tag;
    c.weight = weight;
    c.pdf    = pdf;
    c.inc_w  = inc_w;
    c.inc_m  = inc_m;
    c.rnd    = rnd;
    return c;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  // Q16.16 value: zero, all ones, between 1/256 and 4.0, or anything
  function automatic bit [31:0] rand_q16();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k == 0) return '0;
    if (k == 1) return '1;
    if (k < 5) return $urandom_range(32'h100, 32'h4_0000);
    return $urandom();
  endfunction

  function automatic bit [15:0] rand_count();
    int unsigned k;
    k = $urandom_range(0, 19);
    if (k < 2) return '0;
    if (k == 2) return '1;
    if (k < 15) return 16'($urandom_range(1, 64));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  // add-heavy mix so the reservoir builds up between occasional resets
  function automatic cand_t rand_item();
    int unsigned k;
    action_e     act;
    k = $urandom_range(0, 99);
    if (k < 60) act = ACT_ADD;
    else if (k < 80) act = ACT_MERGE;
    else if (k < 92) act = ACT_REPLACE;
    else act = ACT_RESET;
    return make_item(act, $urandom(), rand_q16(), rand_q16(), rand_q16(), rand_count(),
                     16'($urandom_range(0, 16'hFFFF)));
  endfunction

  // offers one item, waits for the handshake and records the expected result
  task automatic send_item(cand_t c);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.act;
    s_axis_tdata  <= IN_TDATA_W'({c.rnd, c.inc_m, c.inc_w, c.pdf, c.weight, c.tag});
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(advance_reservoir(c));
    n_sent++;
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
  endtask

  // ---------------------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------------------

  // zero weights, zero pdf divisor, W saturation
  task automatic test_add_edges();
    send_item(make_item(ACT_RESET, $urandom(), $urandom(), $urandom(), $urandom(),
                        16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF))));
    send_item(make_item(ACT_ADD, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0));
    send_item(make_item(ACT_ADD, '1, '1, 32'h1, '1, '1, '1));
    send_item(make_item(ACT_ADD, 32'h1234_5678, 32'h1, '1, 32'h0, 16'h0, 16'h0));
    send_item(make_item(ACT_ADD, 32'h8765_4321, 32'h0, 32'h1_0000, 32'h0, 16'h0, 16'h0));
    send_item(make_item(ACT_ADD, 32'hDEAD_BEEF, 32'h1_0000, 32'h0, 32'h0, 16'h0, 16'h8000));
  endtask

  // replace copies the incoming reservoir, count at both ends
  task automatic test_replace_edges();
    send_item(make_item(ACT_REPLACE, 32'hA5A5_A5A5, 32'h0, '1, '1, '1, 16'h0));
    send_item(make_item(ACT_ADD, 32'h5A5A_5A5A, 32'h2, 32'h2_0000, 32'h0, 16'h0, '1));
    send_item(make_item(ACT_REPLACE, 32'h0, '1, 32'h0, 32'h0, 16'h0, '1));
    send_item(make_item(ACT_ADD, 32'h0F0F_0F0F, 32'h3_0000, 32'h1_8000, 32'h0, 16'h0, 16'h0));
  endtask

  // merge of two empty reservoirs, saturated weights and counts, plain merges
  task automatic test_merge_edges();
    send_item(make_item(ACT_RESET, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0));
    send_item(make_item(ACT_MERGE, 32'hCAFE_F00D, '1, '1, '1, 16'h0, 16'h0));
    send_item(make_item(ACT_MERGE, 32'h1111_2222, 32'h0, '1, '1, '1, 16'h0));
    send_item(make_item(ACT_MERGE, 32'h3333_4444, 32'h0, '1, '1, '1, 16'h7FFF));
    send_item(make_item(ACT_REPLACE, 32'h5555_6666, 32'h0, 32'h1_0000, 32'h2_0000, 16'd4,
                        16'h0));
    send_item(make_item(ACT_MERGE, 32'h7777_8888, 32'h0, 32'h8000, 32'h1_0000, 16'd2, 16'h8000));
    send_item(make_item(ACT_MERGE, 32'h9999_AAAA, 32'h0, 32'h1, 32'h1, 16'd1, '1));
    send_item(make_item(ACT_MERGE, 32'hBBBB_CCCC, 32'h0, 32'h0, '1, '1, 16'h0));
  endtask

  task automatic test_random_actions(int n_items);
    repeat (n_items) send_item(rand_item());
  endtask

  // neither side idles for a stretch
  task automatic test_no_idle(int n_items);
    gaps_on     = 1'b0;
    sink_stalls = 1'b0;
    test_random_actions(n_items);
    gaps_on     = 1'b1;
    sink_stalls = 1'b1;
  endtask

  // receiver holds off for a long time while items keep coming, so the input stalls
  task automatic test_output_hold(int n_items);
    hold_req = 1'b1;
    do @(posedge clk_i); while (!hold_active);
    gaps_on = 1'b0;
    test_random_actions(n_items);
    gaps_on = 1'b1;
  endtask

  // sender stops until every result is back, then goes on
  task automatic test_drain_pause(int n_items);
    wait_results_drained();
    test_random_actions(n_items);
  endtask

  // ---------------------------------------------------------------------------------------
  // receiver: random ready, plus a long hold-off on request
  // ---------------------------------------------------------------------------------------

  initial begin : result_sink
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req    = 1'b0;
        hold_active = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_active = 1'b0;
      end else if (!sink_stalls || $urandom_range(0, 2) != 0) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // result check against the oldest expectation
  // ---------------------------------------------------------------------------------------

  task automatic check_field(string name, bit [63:0] want, bit [63:0] got);
    if (want != got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    reservoir_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result item, expected none actual %h", $time, m_axis_tdata);
        n_errors++;
      end else begin
        want = expected_q.pop_front();
        check_field("chosen_tag", want.tag, m_axis_tdata[31:0]);
        check_field("chosen_pdf", want.pdf, m_axis_tdata[63:32]);
        check_field("contribution", want.contrib, m_axis_tdata[95:64]);
        check_field("candidate_count", want.count, m_axis_tdata[111:96]);
        check_field("weight_total", want.total, m_axis_tdata[159:112]);
        check_field("taken", want.taken, m_axis_tuser);
      end
    end
  end

  // watchdog on cycles where no item moves on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
        $display("weighted_reservoir_sampler_unit: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // sequence of tests
  // ---------------------------------------------------------------------------------------

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ACT_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_add_edges();
    test_replace_edges();
    test_merge_edges();
    test_random_actions(250);
    test_no_idle(60);
    test_output_hold(12);
    test_drain_pause(40);
    test_random_actions(120);

    // let everything come back, then make sure nothing else shows up
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_q.size());
      n_errors++;
    end

    $display("sent %0d items, checked %0d results, %0d field errors", n_sent, n_results,
             n_errors);
    $display("covered: edge values of add/merge/replace/reset, random runs, stalls, drain");
    if (n_errors == 0) begin
      $display("weighted_reservoir_sampler_unit: match");
    end else begin
      $display("weighted_reservoir_sampler_unit: mismatch");
    end
    $finish;
  end

endmodule
